@@ hdl/lr_pkg.sv @@
// Shared types and constants for the line rasterizer.
package lr_pkg;

	// Coordinate width of the command and pixel fields
	localparam int COORD_W = 6;

	// Error term: holds values in [-2*major, major + 2*minor)
	localparam int ERR_W = COORD_W + 3;

	// Default grid size
	localparam int GRID_WIDTH_DEF  = 64;
	localparam int GRID_HEIGHT_DEF = 64;

	// Controller states
	typedef enum logic {
		LR_IDLE,
		LR_RUN
	} lr_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // latch and set up a new line
		logic step;   // advance to the next pixel
	} lr_ctrl_t;

	// Datapath to controller status
	typedef struct packed {
		logic last;   // current pixel is the final one
	} lr_status_t;

endpackage

@@ hdl/lr_cmd_if.sv @@
// Line command channel: two endpoints and a pixel value.
interface lr_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [lr_pkg::COORD_W-1:0]  start_x;
	logic [lr_pkg::COORD_W-1:0]  start_y;
	logic [lr_pkg::COORD_W-1:0]  end_x;
	logic [lr_pkg::COORD_W-1:0]  end_y;
	logic                        draw_value;

	modport source (output valid, start_x, start_y, end_x, end_y, draw_value, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, draw_value, output ready);
endinterface

@@ hdl/lr_pix_if.sv @@
// Pixel write channel: one transfer per rasterised pixel.
interface lr_pix_if;
	logic                        valid;
	logic                        ready;
	logic [lr_pkg::COORD_W-1:0]  pixel_x;
	logic [lr_pkg::COORD_W-1:0]  pixel_y;
	logic                        write_value;
	logic                        last;

	modport source (output valid, pixel_x, pixel_y, write_value, last, input ready);
	modport sink   (input valid, pixel_x, pixel_y, write_value, last, output ready);
endinterface

@@ hdl/line_rasterizer.sv @@
// Line rasteriser top level: Bresenham line commands in, pixel writes out.
//
//   channel | dir | payload                                      | transfer
//   cmd     | in  | start_x start_y end_x end_y draw_value       | one per line
//   pix     | out | pixel_x pixel_y write_value last             | one per pixel
//
// A line of major delta N gives N+1 pixel transfers, one per cycle while pix is
// ready; the command itself is accepted in the idle state, ahead of them.
// The pixel walk is a single step register loop; cmd is ready only when idle.
// Reset returns the controller to idle; line registers are not reset.
// A stalled pix holds the current pixel and the step until the transfer.
module line_rasterizer #(
	parameter int GRID_WIDTH  = lr_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lr_pkg::GRID_HEIGHT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	lr_cmd_if.sink   cmd,
	lr_pix_if.source pix
);

	lr_pkg::lr_ctrl_t   ctl;
	lr_pkg::lr_status_t sts;

	// Controller
	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Datapath
	lr_datapath #(
		.GRID_WIDTH  (GRID_WIDTH),
		.GRID_HEIGHT (GRID_HEIGHT)
	) u_datapath (
		.clk         (clk),
		.ctl         (ctl),
		.sts         (sts),
		.start_x     (cmd.start_x),
		.start_y     (cmd.start_y),
		.end_x       (cmd.end_x),
		.end_y       (cmd.end_y),
		.draw_value  (cmd.draw_value),
		.pixel_x     (pix.pixel_x),
		.pixel_y     (pix.pixel_y),
		.write_value (pix.write_value),
		.last        (pix.last)
	);

endmodule

@@ hdl/lr_ctrl.sv @@
// Line rasteriser controller: accepts a command, then runs until the last pixel.
module lr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	output logic               pix_valid,
	input  logic               pix_ready,
	output lr_pkg::lr_ctrl_t   ctl,
	input  lr_pkg::lr_status_t sts
);

	lr_pkg::lr_state_t state_q;
	lr_pkg::lr_state_t state_next;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lr_pkg::LR_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state and outputs
	always_comb begin
		state_next = state_q;
		cmd_ready  = 1'b0;
		pix_valid  = 1'b0;
		ctl.load   = 1'b0;
		ctl.step   = 1'b0;
		case (state_q)
			lr_pkg::LR_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd_valid) begin
					ctl.load   = 1'b1;
					state_next = lr_pkg::LR_RUN;
				end
			end
			lr_pkg::LR_RUN: begin
				pix_valid = 1'b1;
				if (pix_ready) begin
					ctl.step = 1'b1;
					if (sts.last) begin
						state_next = lr_pkg::LR_IDLE;
					end
				end
			end
			default: begin
				state_next = lr_pkg::LR_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/lr_datapath.sv @@
// Line rasteriser datapath: endpoint set-up and Bresenham stepping registers.
module lr_datapath #(
	parameter int GRID_WIDTH  = lr_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = lr_pkg::GRID_HEIGHT_DEF
) (
	input  logic                       clk,
	input  lr_pkg::lr_ctrl_t           ctl,
	output lr_pkg::lr_status_t         sts,
	input  logic [lr_pkg::COORD_W-1:0] start_x,
	input  logic [lr_pkg::COORD_W-1:0] start_y,
	input  logic [lr_pkg::COORD_W-1:0] end_x,
	input  logic [lr_pkg::COORD_W-1:0] end_y,
	input  logic                       draw_value,
	output logic [lr_pkg::COORD_W-1:0] pixel_x,
	output logic [lr_pkg::COORD_W-1:0] pixel_y,
	output logic                       write_value,
	output logic                       last
);

	localparam int CW    = lr_pkg::COORD_W;
	localparam int EW    = lr_pkg::ERR_W;
	localparam int CSPAN = 2 ** CW;
	localparam int XMAX_I = (GRID_WIDTH  > CSPAN) ? CSPAN - 1 : GRID_WIDTH  - 1;
	localparam int YMAX_I = (GRID_HEIGHT > CSPAN) ? CSPAN - 1 : GRID_HEIGHT - 1;
	localparam logic [CW-1:0] XMAX = XMAX_I[CW-1:0];
	localparam logic [CW-1:0] YMAX = YMAX_I[CW-1:0];

	logic [CW-1:0] cx0, cy0, cx1, cy1;
	logic          swap;
	logic [CW-1:0] xa, ya, xb, yb;
	logic [CW-1:0] dx, ady;
	logic          dy_neg, steep;
	logic [CW-1:0] major, minor;

	logic [CW-1:0]        x_q, y_q;
	logic [CW-1:0]        major_q, minor_q, rem_q;
	logic                 steep_q, neg_q, val_q;
	logic signed [EW-1:0] err_q;

	logic signed [EW-1:0] err_sum, major_ext, major2, err_next;
	logic                 minor_step;
	logic [CW-1:0]        y_inc;

	// Saturate endpoints to the grid
	assign cx0 = (start_x > XMAX) ? XMAX : start_x;
	assign cy0 = (start_y > YMAX) ? YMAX : start_y;
	assign cx1 = (end_x   > XMAX) ? XMAX : end_x;
	assign cy1 = (end_y   > YMAX) ? YMAX : end_y;

	// Order endpoints so x never decreases, y increases on a vertical
	assign swap = (cx1 < cx0) || ((cx1 == cx0) && (cy1 < cy0));
	assign xa   = swap ? cx1 : cx0;
	assign ya   = swap ? cy1 : cy0;
	assign xb   = swap ? cx0 : cx1;
	assign yb   = swap ? cy0 : cy1;

	// Deltas and axis choice (x is major on a tie)
	assign dx     = xb - xa;
	assign dy_neg = yb < ya;
	assign ady    = dy_neg ? (ya - yb) : (yb - ya);
	assign steep  = ady > dx;
	assign major  = steep ? ady : dx;
	assign minor  = steep ? dx : ady;

	// Error term update for the next pixel
	assign major_ext  = $signed({{(EW-CW){1'b0}}, major_q});
	assign major2     = $signed({{(EW-CW-1){1'b0}}, major_q, 1'b0});
	assign err_sum    = err_q + $signed({{(EW-CW-1){1'b0}}, minor_q, 1'b0});
	assign minor_step = (major_q != '0) && (err_sum >= major_ext);
	assign err_next   = minor_step ? (err_sum - major2) : err_sum;
	assign y_inc      = neg_q ? (y_q - CW'(1)) : (y_q + CW'(1));

	// Line registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q     <= xa;
			y_q     <= ya;
			major_q <= major;
			minor_q <= minor;
			rem_q   <= major;
			steep_q <= steep;
			neg_q   <= dy_neg;
			val_q   <= draw_value;
			err_q   <= '0;
		end else if (ctl.step) begin
			err_q <= err_next;
			rem_q <= rem_q - CW'(1);
			if (steep_q) begin
				y_q <= y_inc;
				if (minor_step) begin
					x_q <= x_q + CW'(1);
				end
			end else begin
				x_q <= x_q + CW'(1);
				if (minor_step) begin
					y_q <= y_inc;
				end
			end
		end
	end

	assign sts.last    = (rem_q == '0);
	assign pixel_x     = x_q;
	assign pixel_y     = y_q;
	assign write_value = val_q;
	assign last        = (rem_q == '0);

endmodule

@@ sim/lr_pixel_checker.sv @@
// Pixel stream checker for the line rasterizer: predicts each line's pixel writes and compares.
`timescale 1ns / 100ps

module lr_pixel_checker (
	input  logic clk,
	input  logic arst_n,
	lr_cmd_if    cmd,
	lr_pix_if    pix,
	output int   mismatch_count,
	output int   pixels_pending
);

	// One predicted pixel write, tagged with its line and position for reporting
	typedef struct {
		logic [lr_pkg::COORD_W-1:0] x;
		logic [lr_pkg::COORD_W-1:0] y;
		logic                       value;
		logic                       last;
		int                         line_no;
		int                         pixel_no;
	} pixel_write_t;

	pixel_write_t expected_pixels[$];
	int           errors = 0;
	int           pending = 0;
	int           lines_seen = 0;

	assign mismatch_count = errors;
	assign pixels_pending = pending;

	task automatic report_mismatch(input string what, input int line_no, input int pixel_no,
			input int got, input int want);
		$display("%0t: line %0d pixel %0d %s: got %0d, expected %0d",
			$realtime, line_no, pixel_no, what, got, want);
		errors++;
	endtask

	// Bresenham walk: endpoints ordered by x (then y), major axis steps every pixel,
	// minor axis follows an error term scaled by twice the major delta.
	task automatic rasterise_line(input logic [lr_pkg::COORD_W-1:0] sx,
			input logic [lr_pkg::COORD_W-1:0] sy, input logic [lr_pkg::COORD_W-1:0] ex,
			input logic [lr_pkg::COORD_W-1:0] ey, input logic v);
		int x0, y0, x1, y1, tmp;
		int dx, dy, ady, step_y, major_d, minor_d, err_acc, x, y, i;
		bit steep;
		pixel_write_t p;
		x0 = int'(sx);
		y0 = int'(sy);
		x1 = int'(ex);
		y1 = int'(ey);
		if (x1 < x0 || (x1 == x0 && y1 < y0)) begin
			tmp = x0; x0 = x1; x1 = tmp;
			tmp = y0; y0 = y1; y1 = tmp;
		end
		dx = x1 - x0;
		dy = y1 - y0;
		step_y = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
		ady = (dy < 0) ? -dy : dy;
		// vertical lines are the steep case with no minor delta
		steep = (ady > dx);
		major_d = steep ? ady : dx;
		minor_d = steep ? dx : ady;
		x = x0;
		y = y0;
		err_acc = 0;
		for (i = 0; i <= major_d; i++) begin
			p.x = x[lr_pkg::COORD_W-1:0];
			p.y = y[lr_pkg::COORD_W-1:0];
			p.value = v;
			p.last = (i == major_d);
			p.line_no = lines_seen;
			p.pixel_no = i;
			expected_pixels = {expected_pixels, p};
			if (steep)
				y += step_y;
			else
				x += 1;
			err_acc += 2 * minor_d;
			// half a pixel or more: step the minor axis towards the end point
			if (major_d > 0 && err_acc >= major_d) begin
				if (steep)
					x += 1;
				else
					y += step_y;
				err_acc -= 2 * major_d;
			end
		end
		lines_seen++;
	endtask

	// Compare pixel transfers first, then queue up any newly accepted line
	always @(posedge clk) begin
		pixel_write_t want;
		if (arst_n) begin
			if (pix.valid && pix.ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected pixel x", -1, -1, int'(pix.pixel_x), -1);
				end else begin
					want = expected_pixels.pop_front();
					if (pix.pixel_x !== want.x)
						report_mismatch("pixel_x", want.line_no, want.pixel_no,
							int'(pix.pixel_x), int'(want.x));
					if (pix.pixel_y !== want.y)
						report_mismatch("pixel_y", want.line_no, want.pixel_no,
							int'(pix.pixel_y), int'(want.y));
					if (pix.write_value !== want.value)
						report_mismatch("write_value", want.line_no, want.pixel_no,
							int'(pix.write_value), int'(want.value));
					if (pix.last !== want.last)
						report_mismatch("last", want.line_no, want.pixel_no,
							int'(pix.last), int'(want.last));
				end
			end
			if (cmd.valid && cmd.ready)
				rasterise_line(cmd.start_x, cmd.start_y, cmd.end_x, cmd.end_y,
					cmd.draw_value);
			pending = expected_pixels.size();
		end
	end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the line rasterizer: clock, reset, line commands, pixel back-pressure, verdict.
`timescale 1ns / 100ps

module tb_top;

	localparam int CW           = lr_pkg::COORD_W;
	localparam int RANDOM_LINES = 137;
	localparam int DRAIN_CYCLES = 80;
	localparam int IDLE_LIMIT   = 2000;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   pixels_pending;
	int   idle_cycles = 0;
	int   burst_left = 0;

	lr_cmd_if cmd ();
	lr_pix_if pix ();

	line_rasterizer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pix    (pix)
	);

	lr_pixel_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.pix            (pix),
		.mismatch_count (mismatch_count),
		.pixels_pending (pixels_pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: give up after a long stretch with no transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd.valid && cmd.ready) || (pix.valid && pix.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("line_rasterizer test failed");
				$finish;
			end
		end
	end

	// Pixel sink back-pressure: phases of periodic stalls, some with no stall at all
	initial begin
		int phase_left, stall_len, period, cyc;
		pix.ready = 1'b0;
		phase_left = 0;
		stall_len = 0;
		period = 1;
		cyc = 0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				phase_left = $urandom_range(50, 300);
				stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
				period = stall_len + $urandom_range(1, 6);
				cyc = 0;
			end
			pix.ready = (cyc % period) >= stall_len;
			cyc++;
			phase_left--;
		end
	end

	// Offer one line command, with burst/gap idling ahead of it, and hold it until taken
	task automatic send_line(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
			input logic [CW-1:0] ex, input logic [CW-1:0] ey, input logic v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				cmd.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 6);
		end
		cmd.valid = 1'b1;
		cmd.start_x = sx;
		cmd.start_y = sy;
		cmd.end_x = ex;
		cmd.end_y = ey;
		cmd.draw_value = v;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		burst_left--;
		@(negedge clk);
	endtask

	// A coordinate within eight of c, saturated to the grid
	function automatic logic [CW-1:0] nearby(input logic [CW-1:0] c);
		int n;
		n = int'(c) + int'($urandom_range(0, 16)) - 8;
		if (n < 0)
			n = 0;
		if (n > lr_pkg::GRID_WIDTH_DEF - 1)
			n = lr_pkg::GRID_WIDTH_DEF - 1;
		return n[CW-1:0];
	endfunction

	initial begin
		logic [CW-1:0] sx, sy;
		int n;
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.start_x = '0;
		cmd.start_y = '0;
		cmd.end_x = '0;
		cmd.end_y = '0;
		cmd.draw_value = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: single points, grid edges, every octant, vertical runs and exact halves
		send_line(0, 0, 0, 0, 1);
		send_line(63, 63, 63, 63, 0);
		send_line(0, 0, 63, 0, 1);
		send_line(63, 63, 0, 63, 0);
		send_line(5, 0, 5, 63, 1);
		send_line(7, 63, 7, 0, 1);
		send_line(0, 0, 63, 63, 0);
		send_line(0, 63, 63, 0, 1);
		send_line(63, 0, 0, 63, 1);
		send_line(10, 10, 13, 40, 1);
		send_line(13, 40, 10, 10, 0);
		send_line(10, 40, 13, 10, 1);
		send_line(13, 10, 10, 40, 1);
		send_line(40, 10, 10, 13, 0);
		send_line(10, 13, 40, 10, 1);
		send_line(0, 0, 2, 1, 1);
		send_line(0, 0, 1, 2, 1);
		send_line(2, 1, 0, 0, 0);
		send_line(0, 0, 63, 1, 1);
		send_line(0, 63, 1, 0, 1);
		send_line(63, 63, 63, 62, 1);
		send_line(62, 63, 63, 63, 0);
		send_line(21, 42, 42, 21, 1);

		// Random: mostly short lines, the rest anywhere on the grid
		for (n = 0; n < RANDOM_LINES; n++) begin
			sx = CW'($urandom_range(0, 63));
			sy = CW'($urandom_range(0, 63));
			if ($urandom_range(0, 9) < 6)
				send_line(sx, sy, nearby(sx), nearby(sy), 1'($urandom_range(0, 1)));
			else
				send_line(sx, sy, CW'($urandom_range(0, 63)), CW'($urandom_range(0, 63)),
					1'($urandom_range(0, 1)));
		end
		cmd.valid = 1'b0;

		// Drain, then allow time for any stray pixel to show up
		wait (pixels_pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pixels_pending == 0) begin
			$display("line_rasterizer test passed");
		end else begin
			$display("line_rasterizer test failed");
		end
		$finish;
	end

endmodule
